// ----- rtl/core/cps_pkg.sv -----
package cps_pkg;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_WAIT  = 5'b00010,
        ST_PWRON = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_ERROR = 5'b10000
    } t_state;

    localparam logic [2:0] CODE_INIT  = 3'd0;
    localparam logic [2:0] CODE_WAIT  = 3'd1;
    localparam logic [2:0] CODE_PWRON = 3'd2;
    localparam logic [2:0] CODE_RUN   = 3'd3;
    localparam logic [2:0] CODE_ERROR = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHIP_PWR = 2'd1;
    localparam logic [1:0] ERR_TEMP     = 2'd2;

    localparam int unsigned VecW = 4;
    localparam int unsigned InW  = 32;
    localparam int unsigned OutW = 24;

    typedef struct packed {
        logic [VecW-1:0] chip_heartbeat_ok;
        logic [VecW-1:0] chip_off_request;
        logic [VecW-1:0] chip_ready;
        logic [VecW-1:0] chip_in_reset;
        logic [VecW-1:0] chip_power_on_done;
        logic [VecW-1:0] chip_power_good;
        logic            temperature_ok;
        logic            board_power_good;
    } t_status;

    typedef struct packed {
        logic [VecW-1:0] force_off_cmd;
        logic [VecW-1:0] reset_cmd;
        logic [VecW-1:0] power_off_cmd;
        logic [VecW-1:0] power_on_cmd;
        logic            board_reset_pulse;
        logic            board_init_pulse;
    } t_cmds;

    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        case (st)
            ST_INIT:  code = CODE_INIT;
            ST_WAIT:  code = CODE_WAIT;
            ST_PWRON: code = CODE_PWRON;
            ST_RUN:   code = CODE_RUN;
            ST_ERROR: code = CODE_ERROR;
            default:  code = CODE_INIT;
        endcase
        return code;
    endfunction

    // Status bits of chips past the field width read as zero.
    function automatic logic chip_bit(input logic [VecW-1:0] vec, input int unsigned idx);
        logic b;
        b = 1'b0;
        if (idx < VecW) begin
            b = vec[idx[1:0]];
        end
        return b;
    endfunction

endpackage

// ----- rtl/core/cps_step.sv -----
module cps_step #(
    parameter int unsigned NUM_CHIPS = 4
) (
    input  cps_pkg::t_state  i_state,
    input  logic [1:0]       i_err,
    input  cps_pkg::t_status i_status,
    output cps_pkg::t_state  o_state,
    output logic [1:0]       o_err,
    output cps_pkg::t_cmds   o_cmds
);

    localparam int unsigned MaskW = (NUM_CHIPS < cps_pkg::VecW) ? NUM_CHIPS : cps_pkg::VecW;
    localparam logic [cps_pkg::VecW-1:0] AllChips = cps_pkg::VecW'((1 << MaskW) - 1);

    logic            mon_pass;
    cps_pkg::t_state mon_state;
    logic            mon_err;
    logic            mon_rst;
    logic            mon_off;
    logic            wait_pass;
    logic            wait_err;
    logic            hb_ok;

    // Priority scans from chip 0; the first chip that fails decides.
    always_comb begin
        logic found;
        found     = 1'b0;
        mon_pass  = 1'b1;
        mon_state = cps_pkg::ST_RUN;
        mon_err   = 1'b0;
        mon_rst   = 1'b0;
        mon_off   = 1'b0;
        wait_pass = 1'b1;
        wait_err  = 1'b0;
        hb_ok     = 1'b1;
        for (int unsigned i = 0; i < NUM_CHIPS; i++) begin
            if (!found) begin
                if (!cps_pkg::chip_bit(i_status.chip_power_good, i)) begin
                    found     = 1'b1;
                    mon_pass  = 1'b0;
                    mon_err   = 1'b1;
                    mon_state = cps_pkg::ST_ERROR;
                end else if (cps_pkg::chip_bit(i_status.chip_in_reset, i) ||
                             !cps_pkg::chip_bit(i_status.chip_ready, i)) begin
                    found     = 1'b1;
                    mon_pass  = 1'b0;
                    mon_rst   = 1'b1;
                    mon_state = cps_pkg::ST_PWRON;
                end else if (cps_pkg::chip_bit(i_status.chip_off_request, i)) begin
                    found     = 1'b1;
                    mon_pass  = 1'b0;
                    mon_off   = 1'b1;
                    mon_state = cps_pkg::ST_WAIT;
                end
            end
        end
        found = 1'b0;
        for (int unsigned i = 0; i < NUM_CHIPS; i++) begin
            if (!found) begin
                if (!cps_pkg::chip_bit(i_status.chip_power_on_done, i)) begin
                    found     = 1'b1;
                    wait_pass = 1'b0;
                end else if (!cps_pkg::chip_bit(i_status.chip_power_good, i)) begin
                    found     = 1'b1;
                    wait_pass = 1'b0;
                    wait_err  = 1'b1;
                end
            end
            if (!cps_pkg::chip_bit(i_status.chip_heartbeat_ok, i)) begin
                hb_ok = 1'b0;
            end
        end
    end

    always_comb begin
        o_state = i_state;
        o_err   = i_err;
        o_cmds  = '0;
        case (i_state)
            cps_pkg::ST_INIT: begin
                o_cmds.board_init_pulse = 1'b1;
                if (i_status.board_power_good) begin
                    o_state = cps_pkg::ST_WAIT;
                end
            end
            cps_pkg::ST_WAIT: begin
                if (wait_err) begin
                    o_err   = cps_pkg::ERR_CHIP_PWR;
                    o_state = cps_pkg::ST_ERROR;
                end else if (wait_pass) begin
                    o_state = cps_pkg::ST_PWRON;
                end
            end
            cps_pkg::ST_PWRON: begin
                o_cmds.board_reset_pulse = 1'b1;
                o_cmds.power_on_cmd      = AllChips;
                o_cmds.power_off_cmd     = mon_off ? AllChips : '0;
                o_cmds.reset_cmd         = mon_rst ? AllChips : '0;
                o_state                  = mon_state;
                if (mon_err) begin
                    o_err = cps_pkg::ERR_CHIP_PWR;
                end
            end
            cps_pkg::ST_RUN: begin
                o_cmds.power_off_cmd = mon_off ? AllChips : '0;
                o_cmds.reset_cmd     = mon_rst ? AllChips : '0;
                if (!mon_pass) begin
                    o_state = mon_state;
                    if (mon_err) begin
                        o_err = cps_pkg::ERR_CHIP_PWR;
                    end
                end else if (!hb_ok) begin
                    o_state = cps_pkg::ST_WAIT;
                end else if (!i_status.temperature_ok) begin
                    o_err   = cps_pkg::ERR_TEMP;
                    o_state = cps_pkg::ST_ERROR;
                end
            end
            cps_pkg::ST_ERROR: begin
                o_cmds.force_off_cmd = AllChips;
                o_state = i_status.board_power_good ? cps_pkg::ST_WAIT : cps_pkg::ST_INIT;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- rtl/core/chip_power_sequencer.sv -----
// Board power sequencer for up to NUM_CHIPS core chips. Each request on the slave side is one
// tick of status; each tick gives exactly one result on the master side with the new state,
// the sticky error code and the command vectors for that tick. While the master side does not
// stall, a new request is taken every cycle: the request passes an input register, then the
// state machine step fills the result register. The sequencer state advances only when a
// request moves into the result register, and the error code clears only on reset.
module chip_power_sequencer #(
    parameter int unsigned NUM_CHIPS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: board_power_good, temperature_ok, chip_power_good[3:0],
    // chip_power_on_done[3:0], chip_in_reset[3:0], chip_ready[3:0],
    // chip_off_request[3:0], chip_heartbeat_ok[3:0], zero fill.
    input  logic [cps_pkg::InW-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // Fields from bit 0: present_state[2:0], error_kind[1:0], board_init_pulse,
    // board_reset_pulse, power_on_cmd[3:0], power_off_cmd[3:0], reset_cmd[3:0],
    // force_off_cmd[3:0], zero fill.
    output logic [cps_pkg::OutW-1:0]   m_tdata
);

    localparam int unsigned StatusW = $bits(cps_pkg::t_status);
    localparam int unsigned ResultW = 5 + $bits(cps_pkg::t_cmds);
    localparam int unsigned OutW_l = cps_pkg::OutW;

    logic             r_in_valid;
    cps_pkg::t_status r_in_status;
    logic             r_out_valid;
    logic [OutW_l-1:0] r_out_data;
    cps_pkg::t_state  r_state;
    cps_pkg::t_state  n_state;
    logic [1:0]       r_err;
    logic [1:0]       n_err;
    cps_pkg::t_cmds   step_cmds;
    logic             adv_out;

    assign adv_out  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || adv_out;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    cps_step #(
        .NUM_CHIPS(NUM_CHIPS)
    ) u_step (
        .i_state (r_state),
        .i_err   (r_err),
        .i_status(r_in_status),
        .o_state (n_state),
        .o_err   (n_err),
        .o_cmds  (step_cmds)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= cps_pkg::ST_INIT;
            r_err       <= cps_pkg::ERR_NONE;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_err       <= n_err;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_status <= cps_pkg::t_status'(s_tdata[StatusW-1:0]);
        end
        if (adv_out) begin
            r_out_data <= {{(OutW_l-ResultW){1'b0}}, step_cmds, n_err,
                           cps_pkg::state_code(n_state)};
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != cps_pkg::ERR_NONE) |=> (r_err != cps_pkg::ERR_NONE))
        else $error("error code cleared without reset");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv_out |=> $stable(r_state))
        else $error("state moved without a request");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[2:0] == cps_pkg::CODE_ERROR)) |->
        (m_tdata[4:3] != cps_pkg::ERR_NONE))
        else $error("error state reported without error code");

    a_force_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[22:19] != '0)) |->
        ((m_tdata[2:0] == cps_pkg::CODE_WAIT) || (m_tdata[2:0] == cps_pkg::CODE_INIT)))
        else $error("forced off outside the error exit");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [cps_pkg::VecW-1:0] force_off_cmd;
        logic [cps_pkg::VecW-1:0] reset_cmd;
        logic [cps_pkg::VecW-1:0] power_off_cmd;
        logic [cps_pkg::VecW-1:0] power_on_cmd;
        logic                     board_reset_pulse;
        logic                     board_init_pulse;
        logic [1:0]               error_kind;
        logic [2:0]               present_state;
    } t_tick_out;

    localparam logic [cps_pkg::VecW-1:0] ALL_CHIPS = '1;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 10000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [cps_pkg::InW-1:0]    s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [cps_pkg::OutW-1:0]   m_tdata;

    logic [2:0]  seq_state = cps_pkg::CODE_INIT;
    logic [1:0]  seq_error = cps_pkg::ERR_NONE;
    t_tick_out   pending_ticks[$];
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          ticks_checked = 0;
    int          state_hits[5] = '{default: 0};
    bit          steady_run = 1'b0;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    chip_power_sequencer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic chips_healthy(input cps_pkg::t_status st, inout t_tick_out r);
        for (int i = 0; i < cps_pkg::VecW; i++) begin
            if (!st.chip_power_good[i]) begin
                seq_error = cps_pkg::ERR_CHIP_PWR;
                seq_state = cps_pkg::CODE_ERROR;
                return 1'b0;
            end
            if (st.chip_in_reset[i] || !st.chip_ready[i]) begin
                r.reset_cmd = ALL_CHIPS;
                seq_state = cps_pkg::CODE_PWRON;
                return 1'b0;
            end
            if (st.chip_off_request[i]) begin
                r.power_off_cmd = ALL_CHIPS;
                seq_state = cps_pkg::CODE_WAIT;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_tick_out advance_sequencer(input cps_pkg::t_status st);
        t_tick_out r;
        logic all_pass;
        r = '0;
        case (seq_state)
            cps_pkg::CODE_INIT: begin
                r.board_init_pulse = 1'b1;
                if (st.board_power_good) seq_state = cps_pkg::CODE_WAIT;
            end
            cps_pkg::CODE_WAIT: begin
                all_pass = 1'b1;
                for (int i = 0; i < cps_pkg::VecW; i++) begin
                    if (!st.chip_power_on_done[i]) begin
                        all_pass = 1'b0;
                        break;
                    end
                    if (!st.chip_power_good[i]) begin
                        seq_error = cps_pkg::ERR_CHIP_PWR;
                        seq_state = cps_pkg::CODE_ERROR;
                        all_pass = 1'b0;
                        break;
                    end
                end
                if (all_pass) seq_state = cps_pkg::CODE_PWRON;
            end
            cps_pkg::CODE_PWRON: begin
                r.board_reset_pulse = 1'b1;
                r.power_on_cmd = ALL_CHIPS;
                if (chips_healthy(st, r)) seq_state = cps_pkg::CODE_RUN;
            end
            cps_pkg::CODE_RUN: begin
                if (chips_healthy(st, r)) begin
                    if (st.chip_heartbeat_ok != ALL_CHIPS) begin
                        seq_state = cps_pkg::CODE_WAIT;
                    end else if (!st.temperature_ok) begin
                        seq_error = cps_pkg::ERR_TEMP;
                        seq_state = cps_pkg::CODE_ERROR;
                    end
                end
            end
            cps_pkg::CODE_ERROR: begin
                r.force_off_cmd = ALL_CHIPS;
                seq_state = st.board_power_good ? cps_pkg::CODE_WAIT : cps_pkg::CODE_INIT;
            end
            default: begin
            end
        endcase
        r.present_state = seq_state;
        r.error_kind = seq_error;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tick_out want;
        if (i_rst_n && s_tvalid && s_tready) begin
            want = advance_sequencer(
                cps_pkg::t_status'(s_tdata[$bits(cps_pkg::t_status)-1:0]));
            if (want.present_state <= cps_pkg::CODE_ERROR) state_hits[want.present_state]++;
            pending_ticks.push_back(want);
            ticks_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_tick_out want;
        t_tick_out got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[$bits(t_tick_out)-1:0];
            if (pending_ticks.size() == 0) begin
                $error("result arrived with no request outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_ticks.pop_front();
                check_field("present_state", want.present_state, got.present_state);
                check_field("error_kind", want.error_kind, got.error_kind);
                check_field("board_init_pulse", want.board_init_pulse, got.board_init_pulse);
                check_field("board_reset_pulse", want.board_reset_pulse,
                            got.board_reset_pulse);
                check_field("power_on_cmd", want.power_on_cmd, got.power_on_cmd);
                check_field("power_off_cmd", want.power_off_cmd, got.power_off_cmd);
                check_field("reset_cmd", want.reset_cmd, got.reset_cmd);
                check_field("force_off_cmd", want.force_off_cmd, got.force_off_cmd);
                check_field("zero_fill", 0, m_tdata[cps_pkg::OutW-1:$bits(t_tick_out)]);
                ticks_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_run || ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic cps_pkg::t_status nominal_status();
        cps_pkg::t_status st;
        st.board_power_good   = 1'b1;
        st.temperature_ok     = 1'b1;
        st.chip_power_good    = ALL_CHIPS;
        st.chip_power_on_done = ALL_CHIPS;
        st.chip_in_reset      = '0;
        st.chip_ready         = ALL_CHIPS;
        st.chip_off_request   = '0;
        st.chip_heartbeat_ok  = ALL_CHIPS;
        return st;
    endfunction

    function automatic logic [cps_pkg::VecW-1:0] disturb_vec(
        input logic [cps_pkg::VecW-1:0] v, input int pct);
        logic [cps_pkg::VecW-1:0] flip;
        logic [31:0]              raw;
        int unsigned              pos;
        if ($urandom_range(0, 99) < pct) begin
            if ($urandom_range(0, 1) == 0) begin
                pos = $urandom_range(0, cps_pkg::VecW-1);
                flip = '0;
                flip[pos] = 1'b1;
                v = v ^ flip;
            end else begin
                raw = $urandom;
                v = raw[cps_pkg::VecW-1:0];
            end
        end
        return v;
    endfunction

    function automatic cps_pkg::t_status disturbed_status(input int pct);
        cps_pkg::t_status st;
        st = nominal_status();
        if ($urandom_range(0, 99) < pct) st.board_power_good = 1'b0;
        if ($urandom_range(0, 99) < pct) st.temperature_ok = 1'b0;
        st.chip_power_good    = disturb_vec(st.chip_power_good, pct);
        st.chip_power_on_done = disturb_vec(st.chip_power_on_done, pct);
        st.chip_in_reset      = disturb_vec(st.chip_in_reset, pct);
        st.chip_ready         = disturb_vec(st.chip_ready, pct);
        st.chip_off_request   = disturb_vec(st.chip_off_request, pct);
        st.chip_heartbeat_ok  = disturb_vec(st.chip_heartbeat_ok, pct);
        return st;
    endfunction

    task automatic offer_status(input cps_pkg::t_status st);
        if (!steady_run && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(cps_pkg::InW - $bits(cps_pkg::t_status)){1'b0}}, st};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic test_init_exit();
        cps_pkg::t_status st;
        offer_status('0);
        st = nominal_status();
        st.board_power_good = 1'b0;
        offer_status(st);
        offer_status(nominal_status());
    endtask

    task automatic test_wait_checks();
        cps_pkg::t_status st;
        st = nominal_status();
        st.chip_power_on_done = 4'b1011;
        offer_status(st);
        st = nominal_status();
        st.chip_power_good = 4'b0111;
        offer_status(st);
    endtask

    task automatic test_error_exit();
        cps_pkg::t_status st;
        st = nominal_status();
        st.board_power_good = 1'b0;
        offer_status(st);
        offer_status(nominal_status());
        offer_status('1);
    endtask

    task automatic test_power_on_monitor();
        cps_pkg::t_status st;
        st = nominal_status();
        st.chip_power_good = 4'b1011;
        st.chip_in_reset = 4'b0010;
        offer_status(st);
        st = nominal_status();
        st.chip_ready = 4'b1110;
        offer_status(st);
        st = nominal_status();
        st.chip_off_request = 4'b1000;
        offer_status(st);
        offer_status(nominal_status());
        offer_status(nominal_status());
    endtask

    task automatic test_run_checks();
        cps_pkg::t_status st;
        offer_status(nominal_status());
        st = nominal_status();
        st.chip_heartbeat_ok = 4'b1011;
        offer_status(st);
        offer_status(nominal_status());
        offer_status(nominal_status());
        st = nominal_status();
        st.temperature_ok = 1'b0;
        offer_status(st);
        repeat (3) offer_status(nominal_status());
        st = nominal_status();
        st.chip_power_good = 4'b1101;
        offer_status(st);
        st = nominal_status();
        st.board_power_good = 1'b0;
        st.temperature_ok = 1'b0;
        offer_status(st);
    endtask

    task automatic test_backpressure();
        hold_asked++;
        repeat (40) offer_status(disturbed_status(4));
    endtask

    task automatic test_random_traffic(input int count);
        logic [31:0] raw;
        cps_pkg::t_status st;
        for (int k = 0; k < count; k++) begin
            steady_run = (k >= 300 && k < 450);
            if ($urandom_range(0, 99) < 8) begin
                raw = $urandom;
                st = raw[$bits(cps_pkg::t_status)-1:0];
            end else begin
                st = disturbed_status($urandom_range(2, 8));
            end
            offer_status(st);
        end
        steady_run = 1'b0;
    endtask

    initial begin
        int drain;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_init_exit();
        test_wait_checks();
        test_error_exit();
        test_power_on_monitor();
        test_run_checks();
        test_backpressure();
        test_random_traffic(880);
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_ticks.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_ticks.size() != 0) begin
            $error("%0d results never arrived", pending_ticks.size());
            mismatches++;
        end
        $display("Sent %0d status ticks and checked %0d results, with stalls on both sides.",
                 ticks_sent, ticks_checked);
        $display("Ticks ending in init %0d, wait %0d, power on %0d, run %0d, error %0d.",
                 state_hits[cps_pkg::CODE_INIT], state_hits[cps_pkg::CODE_WAIT],
                 state_hits[cps_pkg::CODE_PWRON], state_hits[cps_pkg::CODE_RUN],
                 state_hits[cps_pkg::CODE_ERROR]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/cps_pkg.sv
rtl/core/cps_step.sv
rtl/core/chip_power_sequencer.sv
tb/testbench.sv
